### rtl/sha512_pkg.sv
`timescale 1ns / 1ps
package sha512_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 8;
    localparam int ROUNDS      = 80;
    localparam logic [6:0] LEN_FILL  = 7'd112;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    typedef logic [63:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
        t_word f;
        t_word g;
        t_word h;
    } t_work;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT_RD,
        ST_OUT_CAP,
        ST_OUT_HOLD
    } t_state;

    function automatic t_word f_iv(input logic [2:0] i);
        t_word v;
        unique case (i)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            default: v = 64'h5be0cd19137e2179;
        endcase
        return v;
    endfunction

    function automatic t_word f_k(input logic [6:0] r);
        t_word v;
        case (r)
            7'd0:  v = 64'h428a2f98d728ae22;  7'd1:  v = 64'h7137449123ef65cd;
            7'd2:  v = 64'hb5c0fbcfec4d3b2f;  7'd3:  v = 64'he9b5dba58189dbbc;
            7'd4:  v = 64'h3956c25bf348b538;  7'd5:  v = 64'h59f111f1b605d019;
            7'd6:  v = 64'h923f82a4af194f9b;  7'd7:  v = 64'hab1c5ed5da6d8118;
            7'd8:  v = 64'hd807aa98a3030242;  7'd9:  v = 64'h12835b0145706fbe;
            7'd10: v = 64'h243185be4ee4b28c;  7'd11: v = 64'h550c7dc3d5ffb4e2;
            7'd12: v = 64'h72be5d74f27b896f;  7'd13: v = 64'h80deb1fe3b1696b1;
            7'd14: v = 64'h9bdc06a725c71235;  7'd15: v = 64'hc19bf174cf692694;
            7'd16: v = 64'he49b69c19ef14ad2;  7'd17: v = 64'hefbe4786384f25e3;
            7'd18: v = 64'h0fc19dc68b8cd5b5;  7'd19: v = 64'h240ca1cc77ac9c65;
            7'd20: v = 64'h2de92c6f592b0275;  7'd21: v = 64'h4a7484aa6ea6e483;
            7'd22: v = 64'h5cb0a9dcbd41fbd4;  7'd23: v = 64'h76f988da831153b5;
            7'd24: v = 64'h983e5152ee66dfab;  7'd25: v = 64'ha831c66d2db43210;
            7'd26: v = 64'hb00327c898fb213f;  7'd27: v = 64'hbf597fc7beef0ee4;
            7'd28: v = 64'hc6e00bf33da88fc2;  7'd29: v = 64'hd5a79147930aa725;
            7'd30: v = 64'h06ca6351e003826f;  7'd31: v = 64'h142929670a0e6e70;
            7'd32: v = 64'h27b70a8546d22ffc;  7'd33: v = 64'h2e1b21385c26c926;
            7'd34: v = 64'h4d2c6dfc5ac42aed;  7'd35: v = 64'h53380d139d95b3df;
            7'd36: v = 64'h650a73548baf63de;  7'd37: v = 64'h766a0abb3c77b2a8;
            7'd38: v = 64'h81c2c92e47edaee6;  7'd39: v = 64'h92722c851482353b;
            7'd40: v = 64'ha2bfe8a14cf10364;  7'd41: v = 64'ha81a664bbc423001;
            7'd42: v = 64'hc24b8b70d0f89791;  7'd43: v = 64'hc76c51a30654be30;
            7'd44: v = 64'hd192e819d6ef5218;  7'd45: v = 64'hd69906245565a910;
            7'd46: v = 64'hf40e35855771202a;  7'd47: v = 64'h106aa07032bbd1b8;
            7'd48: v = 64'h19a4c116b8d2d0c8;  7'd49: v = 64'h1e376c085141ab53;
            7'd50: v = 64'h2748774cdf8eeb99;  7'd51: v = 64'h34b0bcb5e19b48a8;
            7'd52: v = 64'h391c0cb3c5c95a63;  7'd53: v = 64'h4ed8aa4ae3418acb;
            7'd54: v = 64'h5b9cca4f7763e373;  7'd55: v = 64'h682e6ff3d6b2b8a3;
            7'd56: v = 64'h748f82ee5defb2fc;  7'd57: v = 64'h78a5636f43172f60;
            7'd58: v = 64'h84c87814a1f0ab72;  7'd59: v = 64'h8cc702081a6439ec;
            7'd60: v = 64'h90befffa23631e28;  7'd61: v = 64'ha4506cebde82bde9;
            7'd62: v = 64'hbef9a3f7b2c67915;  7'd63: v = 64'hc67178f2e372532b;
            7'd64: v = 64'hca273eceea26619c;  7'd65: v = 64'hd186b8c721c0c207;
            7'd66: v = 64'heada7dd6cde0eb1e;  7'd67: v = 64'hf57d4f7fee6ed178;
            7'd68: v = 64'h06f067aa72176fba;  7'd69: v = 64'h0a637dc5a2c898a6;
            7'd70: v = 64'h113f9804bef90dae;  7'd71: v = 64'h1b710b35131c471b;
            7'd72: v = 64'h28db77f523047d84;  7'd73: v = 64'h32caab7b40c72493;
            7'd74: v = 64'h3c9ebe0a15c9bebc;  7'd75: v = 64'h431d67c49c100d4c;
            7'd76: v = 64'h4cc5d4becb3e42b6;  7'd77: v = 64'h597f299cfc657e2a;
            7'd78: v = 64'h5fcb6fab3ad6faec;  7'd79: v = 64'h6c44198c4a475817;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/sha512_if.sv
`timescale 1ns / 1ps
interface sha512_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/sha512_round.sv
`timescale 1ns / 1ps
module sha512_round (
    input  sha512_pkg::t_work i_work,
    input  sha512_pkg::t_word i_k,
    input  sha512_pkg::t_word i_w0,
    input  sha512_pkg::t_word i_w1,
    input  sha512_pkg::t_word i_w9,
    input  sha512_pkg::t_word i_w14,
    output sha512_pkg::t_work o_work,
    output sha512_pkg::t_word o_wnext
);
    import sha512_pkg::*;

    t_word big_s0, big_s1, ch, maj, t1, t2, sm0, sm1;

    always_comb begin
        big_s1 = {i_work.e[13:0], i_work.e[63:14]} ^ {i_work.e[17:0], i_work.e[63:18]}
               ^ {i_work.e[40:0], i_work.e[63:41]};
        big_s0 = {i_work.a[27:0], i_work.a[63:28]} ^ {i_work.a[33:0], i_work.a[63:34]}
               ^ {i_work.a[38:0], i_work.a[63:39]};
        ch  = (i_work.e & i_work.f) ^ (~i_work.e & i_work.g);
        maj = (i_work.a & i_work.b) ^ (i_work.a & i_work.c) ^ (i_work.b & i_work.c);
        t1  = i_work.h + big_s1 + ch + i_k + i_w0;
        t2  = big_s0 + maj;
        o_work.h = i_work.g;
        o_work.g = i_work.f;
        o_work.f = i_work.e;
        o_work.e = i_work.d + t1;
        o_work.d = i_work.c;
        o_work.c = i_work.b;
        o_work.b = i_work.a;
        o_work.a = t1 + t2;
        sm0 = {i_w1[0], i_w1[63:1]} ^ {i_w1[7:0], i_w1[63:8]} ^ (i_w1 >> 7);
        sm1 = {i_w14[18:0], i_w14[63:19]} ^ {i_w14[60:0], i_w14[63:61]} ^ (i_w14 >> 6);
        o_wnext = i_w0 + sm0 + i_w9 + sm1;
    end

endmodule

### rtl/sha512_hash_engine_unit.sv
`timescale 1ns / 1ps
// SHA-512 engine. One beat carries at most one message byte; bytes are taken one per
// cycle while a block fills. Each full 128-byte block then holds the input off while
// the block and chaining memories load (one word per cycle, registered read), the 80
// rounds run on the single round unit, and the working words are added back into the
// chaining memory. Closing a message pads zero bytes after the 0x80 byte up to byte
// 112, writes the two length words, runs one or two compressions, and sends each
// digest word through a read, capture and hold state, holding while the sink is not
// ready. The engine then returns to the initial hash values for the next message.
module sha512_hash_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha512_in_if.sink           i_in,
    sha512_out_if.source        o_out
);
    import sha512_pkg::*;

    t_word  blk_mem [BLOCK_WORDS];
    t_word  cv_mem  [CHAIN_WORDS];

    t_state       r_state, n_state;
    logic [6:0]   r_cnt, n_cnt;
    logic [6:0]   r_fill, n_fill;
    logic [55:0]  r_word, n_word;
    logic [127:0] r_bits, n_bits;
    logic         r_pad, n_pad, r_mark, n_mark, r_last, n_last;
    logic [7:0]   r_cv_valid;
    t_work        r_work, n_work;
    t_word        r_win [BLOCK_WORDS];
    t_word        n_win [BLOCK_WORDS];
    t_word        r_blk_rd, r_cv_rd;
    logic         r_cv_rdv;
    logic [2:0]   r_cv_ra;
    t_word        r_o_word, n_o_word;
    logic         r_o_valid, n_o_valid;

    logic         push_en;
    logic [7:0]   push_byte;
    logic         blk_we, blk_re, cv_we, cv_re;
    logic [3:0]   blk_wa, blk_ra;
    logic [2:0]   cv_wa, cv_ra;
    t_word        blk_wd, cv_wd, cv_data;
    t_work        rnd_work;
    t_word        rnd_wnext;

    assign cv_data = r_cv_rdv ? r_cv_rd : f_iv(r_cv_ra);

    sha512_round u_round (
        .i_work  (r_work),
        .i_k     (f_k(r_cnt)),
        .i_w0    (r_win[0]),
        .i_w1    (r_win[1]),
        .i_w9    (r_win[9]),
        .i_w14   (r_win[14]),
        .o_work  (rnd_work),
        .o_wnext (rnd_wnext)
    );

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_o_valid;
    assign o_out.digest_word = r_o_word;
    assign o_out.word_index  = r_cnt[2:0];
    assign o_out.last_word   = (r_cnt[2:0] == 3'd7);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_fill    = r_fill;
        n_word    = r_word;
        n_bits    = r_bits;
        n_pad     = r_pad;
        n_mark    = r_mark;
        n_last    = r_last;
        n_work    = r_work;
        n_win     = r_win;
        n_o_word  = r_o_word;
        n_o_valid = r_o_valid;
        push_en   = 1'b0;
        push_byte = 8'h00;
        blk_re    = 1'b0;
        blk_ra    = r_cnt[3:0];
        cv_re     = 1'b0;
        cv_ra     = r_cnt[2:0];
        cv_we     = 1'b0;
        cv_wa     = r_cnt[2:0] - 3'd1;
        cv_wd     = cv_data + r_work.a;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.byte_valid) begin
                        push_en   = 1'b1;
                        push_byte = i_in.data_byte;
                        n_bits    = r_bits + 128'd8;
                    end
                    if (i_in.end_of_message) begin
                        n_pad   = 1'b1;
                        n_mark  = 1'b0;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (!r_mark) begin
                    push_en   = 1'b1;
                    push_byte = PAD_BYTE;
                    n_mark    = 1'b1;
                end else if (r_fill == LEN_FILL) begin
                    n_state = ST_LEN;
                    n_cnt   = '0;
                end else begin
                    push_en = 1'b1;
                end
            end
            ST_LEN: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt[0]) begin
                    n_last  = 1'b1;
                    n_state = ST_LOAD;
                    n_cnt   = '0;
                end
            end
            ST_LOAD: begin
                blk_re = (r_cnt < 7'd16);
                cv_re  = (r_cnt < 7'd8);
                n_cnt  = r_cnt + 7'd1;
                if (r_cnt != 7'd0) begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++) n_win[i] = r_win[i+1];
                    n_win[BLOCK_WORDS-1] = r_blk_rd;
                end
                if (r_cnt != 7'd0 && r_cnt <= 7'd8) begin
                    n_work = {r_work.b, r_work.c, r_work.d, r_work.e,
                              r_work.f, r_work.g, r_work.h, cv_data};
                end
                if (r_cnt == 7'd16) begin
                    n_state = ST_ROUND;
                    n_cnt   = '0;
                end
            end
            ST_ROUND: begin
                n_work = rnd_work;
                for (int i = 0; i < BLOCK_WORDS - 1; i++) n_win[i] = r_win[i+1];
                n_win[BLOCK_WORDS-1] = rnd_wnext;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(ROUNDS - 1)) begin
                    n_state = ST_FINAL;
                    n_cnt   = '0;
                end
            end
            ST_FINAL: begin
                cv_re = (r_cnt < 7'd8);
                n_cnt = r_cnt + 7'd1;
                if (r_cnt != 7'd0) begin
                    cv_we  = 1'b1;
                    n_work = {r_work.b, r_work.c, r_work.d, r_work.e,
                              r_work.f, r_work.g, r_work.h, r_work.a};
                end
                if (r_cnt == 7'd8) begin
                    n_cnt = '0;
                    if (r_last)     n_state = ST_OUT_RD;
                    else if (r_pad) n_state = ST_PAD;
                    else            n_state = ST_IDLE;
                end
            end
            ST_OUT_RD: begin
                cv_re   = 1'b1;
                n_state = ST_OUT_CAP;
            end
            ST_OUT_CAP: begin
                n_o_word  = cv_data;
                n_o_valid = 1'b1;
                n_state   = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (o_out.ready) begin
                    n_o_valid = 1'b0;
                    if (r_cnt[2:0] == 3'd7) begin
                        n_fill  = '0;
                        n_bits  = '0;
                        n_pad   = 1'b0;
                        n_mark  = 1'b0;
                        n_last  = 1'b0;
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 7'd1;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        blk_we = 1'b0;
        blk_wa = r_fill[6:3];
        blk_wd = {r_word, push_byte};
        if (r_state == ST_LEN) begin
            blk_we = 1'b1;
            blk_wa = r_cnt[0] ? 4'd15 : 4'd14;
            blk_wd = r_cnt[0] ? r_bits[63:0] : r_bits[127:64];
        end
        if (push_en) begin
            n_word = {r_word[47:0], push_byte};
            n_fill = r_fill + 7'd1;
            blk_we = (r_fill[2:0] == 3'd7);
            if (r_fill == 7'd127) begin
                n_state = ST_LOAD;
                n_cnt   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_fill     <= '0;
            r_bits     <= '0;
            r_pad      <= 1'b0;
            r_mark     <= 1'b0;
            r_last     <= 1'b0;
            r_cv_valid <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_fill    <= n_fill;
            r_bits    <= n_bits;
            r_pad     <= n_pad;
            r_mark    <= n_mark;
            r_last    <= n_last;
            r_o_valid <= n_o_valid;
            if (r_state == ST_OUT_HOLD && o_out.ready && r_cnt[2:0] == 3'd7) begin
                r_cv_valid <= '0;
            end else if (cv_we) begin
                r_cv_valid[cv_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word   <= n_word;
        r_work   <= n_work;
        r_win    <= n_win;
        r_o_word <= n_o_word;
    end

    always_ff @(posedge i_clk) begin
        if (blk_we) blk_mem[blk_wa] <= blk_wd;
        if (blk_re) r_blk_rd <= blk_mem[blk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cv_we) cv_mem[cv_wa] <= cv_wd;
        if (cv_re) begin
            r_cv_rd  <= cv_mem[cv_ra];
            r_cv_rdv <= r_cv_valid[cv_ra];
            r_cv_ra  <= cv_ra;
        end
    end

endmodule

### bench/tb_sha512_hash_engine_unit.sv
`timescale 1ns / 1ps
module tb_sha512_hash_engine_unit;
    import sha512_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_beat;

    typedef struct packed {
        t_word      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } t_digest;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sha512_in_if  in_ch ();
    sha512_out_if out_ch ();

    sha512_hash_engine_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_beat   pending_beats[$];
    t_digest expected_words[$];
    int      send_idle_pct = 13;
    int      recv_idle_pct = 75;
    bit      stimulus_done = 1'b0;
    int      error_count = 0;
    int      quiet_cycles = 0;

    // predictor state
    t_word      hash_state[8];
    logic [7:0] msg_block[128];
    int         block_fill;
    logic [127:0] msg_bits;

    localparam t_word ROUND_K[80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam t_word START_HASH[8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    function automatic t_word rotr(t_word x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic restart_hash();
        for (int k = 0; k < 8; k++) hash_state[k] = START_HASH[k];
        for (int k = 0; k < 128; k++) msg_block[k] = 8'h00;
        block_fill = 0;
        msg_bits = '0;
    endtask

    task automatic compress_msg_block();
        t_word w[80];
        t_word v[8];
        t_word t1, t2, s0, s1;
        for (int k = 0; k < 16; k++)
            for (int b = 0; b < 8; b++) w[k] = {w[k][55:0], msg_block[k*8 + b]};
        for (int r = 16; r < 80; r++) begin
            s0 = rotr(w[r-15], 1) ^ rotr(w[r-15], 8) ^ (w[r-15] >> 7);
            s1 = rotr(w[r-2], 19) ^ rotr(w[r-2], 61) ^ (w[r-2] >> 6);
            w[r] = w[r-16] + s0 + w[r-7] + s1;
        end
        for (int k = 0; k < 8; k++) v[k] = hash_state[k];
        for (int r = 0; r < 80; r++) begin
            t1 = v[7] + (rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
            t2 = (rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++) hash_state[k] += v[k];
    endtask

    task automatic predict_beat(t_beat bt);
        t_digest d;
        if (bt.byte_valid) begin
            msg_block[block_fill] = bt.data_byte;
            block_fill++;
            msg_bits += 128'd8;
            if (block_fill == 128) begin
                compress_msg_block();
                block_fill = 0;
            end
        end
        if (bt.end_of_message) begin
            msg_block[block_fill] = PAD_BYTE;
            block_fill++;
            if (block_fill > 112) begin
                for (int k = block_fill; k < 128; k++) msg_block[k] = 8'h00;
                compress_msg_block();
                block_fill = 0;
            end
            for (int k = block_fill; k < 112; k++) msg_block[k] = 8'h00;
            for (int k = 0; k < 16; k++) msg_block[112 + k] = msg_bits[127 - 8*k -: 8];
            compress_msg_block();
            for (int k = 0; k < 8; k++) begin
                d.digest_word = hash_state[k];
                d.word_index = 3'(k);
                d.last_word = (k == 7);
                expected_words.push_back(d);
            end
            restart_hash();
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= '0;
            in_ch.byte_valid <= 1'b0;
            in_ch.end_of_message <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_beat({in_ch.data_byte, in_ch.byte_valid, in_ch.end_of_message});
                void'(pending_beats.pop_front());
            end
            if ((!in_ch.valid || in_ch.ready) || 1'b1) begin
                if (in_ch.valid && !in_ch.ready) begin
                    // hold current beat
                end else if (pending_beats.size() > 0 &&
                             $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid <= 1'b1;
                    {in_ch.data_byte, in_ch.byte_valid, in_ch.end_of_message}
                        <= pending_beats[0];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_digest exp_w;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected digest word %h", out_ch.digest_word);
                    error_count++;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (out_ch.digest_word !== exp_w.digest_word) begin
                        $error("digest_word exp %h got %h", exp_w.digest_word,
                               out_ch.digest_word);
                        error_count++;
                    end
                    if (out_ch.word_index !== exp_w.word_index) begin
                        $error("word_index exp %0d got %0d", exp_w.word_index,
                               out_ch.word_index);
                        error_count++;
                    end
                    if (out_ch.last_word !== exp_w.last_word) begin
                        $error("last_word exp %0d got %0d", exp_w.last_word,
                               out_ch.last_word);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_message(int len, int mode);
        t_beat bt;
        for (int k = 0; k < len; k++) begin
            bt.byte_valid = 1'b1;
            bt.end_of_message = 1'b0;
            case (mode)
                1: bt.data_byte = 8'h00;
                2: bt.data_byte = 8'hff;
                default: bt.data_byte = 8'($urandom);
            endcase
            // occasional empty beat
            if (mode == 0 && $urandom_range(9) == 0) begin
                bt.byte_valid = 1'b0;
                bt.data_byte = 8'($urandom);
                pending_beats.push_back(bt);
                bt.byte_valid = 1'b1;
                bt.data_byte = 8'($urandom);
            end
            if (k == len - 1 && $urandom_range(1)) bt.end_of_message = 1'b1;
            pending_beats.push_back(bt);
        end
        if (len == 0 || !pending_beats[$].end_of_message) begin
            bt.byte_valid = 1'b0;
            bt.data_byte = 8'($urandom);
            bt.end_of_message = 1'b1;
            pending_beats.push_back(bt);
        end
    endtask

    task automatic run_phase(int items);
        int target;
        target = items;
        while (target > 0) begin
            int len;
            case ($urandom_range(5))
                0: len = $urandom_range(3);
                1: len = 110 + $urandom_range(8);
                2: len = 127 + $urandom_range(2);
                default: len = $urandom_range(60);
            endcase
            queue_message(len, 0);
            target -= len + 1;
        end
    endtask

    task automatic drain();
        wait (pending_beats.size() == 0 && expected_words.size() == 0);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.byte_valid = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        restart_hash();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, zero/ones bytes, lone idle beat, pad edge lengths
        queue_message(0, 0);
        pending_beats.push_back('{8'hA5, 1'b0, 1'b0});
        queue_message(3, 1);
        queue_message(3, 2);
        queue_message(111, 0);
        queue_message(112, 0);
        drain();

        run_phase(50);
        drain();
        send_idle_pct = 75;
        recv_idle_pct = 13;
        run_phase(50);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(40);
        drain();
        repeat (50) @(posedge i_clk);
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done || quiet_cycles >= WATCHDOG_LIMIT);
        if (!stimulus_done) begin
            $display("sha512_hash_engine_unit test failed");
        end else if (error_count == 0 && expected_words.size() == 0) begin
            $display("sha512_hash_engine_unit test passed");
        end else begin
            $display("sha512_hash_engine_unit test failed");
        end
        $finish;
    end

endmodule
